>>> hw/rtl/fftp_pkg.sv
// Shared types and constants of the first-fit record page table.
// Holds the transaction payload structs, operation and result codes, and parameter defaults.
// No dependencies.
package fftp_pkg;

   localparam int unsigned MaxPagesDefault   = 16;
   localparam int unsigned MaxRecordsDefault = 64;
   localparam int unsigned KeyBitsDefault    = 32;

   localparam int unsigned SlotOverhead      = 4;
   localparam logic [15:0] UsableSpaceReset  = 16'd4080;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_STATUS = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [2:0] KIND_INSERTED = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_TOTAL    = 3'd2;
   localparam logic [2:0] KIND_COUNT    = 3'd3;
   localparam logic [2:0] KIND_HIT      = 3'd4;
   localparam logic [2:0] KIND_MISS     = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] record_size;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [3:0] page_index;
      logic [6:0] value;
      logic       last;
   } rsp_type;

endpackage

>>> hw/rtl/fftp_ram.sv
// Single-port RAM with registered read data.
// Used for the page table and the key store; no dependencies.
module fftp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fftp_ctrl.sv
// Sequencer of the page table: walks pages and key slots, with one shared
// subtractor for free space against record cost, and drives the result register.
// Depends on fftp_pkg; addresses the two fftp_ram instances of the top level.
module fftp_ctrl #(
   parameter int unsigned MAX_PAGES            = fftp_pkg::MaxPagesDefault,
   parameter int unsigned MAX_RECORDS_PER_PAGE = fftp_pkg::MaxRecordsDefault,
   parameter int unsigned KEY_BITS             = fftp_pkg::KeyBitsDefault,
   localparam int unsigned PCW   = $clog2(MAX_PAGES + 1),
   localparam int unsigned PAW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
   localparam int unsigned CW    = $clog2(MAX_RECORDS_PER_PAGE + 1),
   localparam int unsigned KDEP  = MAX_PAGES * MAX_RECORDS_PER_PAGE,
   localparam int unsigned KCW   = $clog2(KDEP + 1),
   localparam int unsigned KAW   = (KDEP > 1) ? $clog2(KDEP) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fftp_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fftp_pkg::rsp_type     rsp_data,
   input  logic [15:0]           usable_space,
   output logic                  page_we,
   output logic [PAW-1:0]        page_addr,
   output logic [CW+15:0]        page_wdata,
   input  logic [CW+15:0]        page_rdata,
   output logic                  key_we,
   output logic [KAW-1:0]        key_addr,
   output logic [KEY_BITS-1:0]   key_wdata,
   input  logic [KEY_BITS-1:0]   key_rdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_INS_NEW,
      S_ST_TOT,
      S_ST_RD,
      S_ST_EMIT,
      S_SR_RD,
      S_SR_CHK,
      S_SR_SCAN,
      S_SR_END,
      S_SR_FIN
   } state_type;

   state_type             state_ff,     state_in;
   logic [16:0]           cost_ff,      cost_in;
   logic [KEY_BITS-1:0]   key_ff,       key_in;
   logic [PCW-1:0]        pages_ff,     pages_in;
   logic [PCW-1:0]        page_ff,      page_in;
   logic [KCW-1:0]        base_ff,      base_in;
   logic [CW-1:0]         cnt_ff,       cnt_in;
   logic [CW-1:0]         slot_ff,      slot_in;
   logic [CW-1:0]         copies_ff,    copies_in;
   logic                  cmp_pend_ff,  cmp_pend_in;
   logic                  hit_valid_ff, hit_valid_in;
   logic [PCW-1:0]        hit_page_ff,  hit_page_in;
   logic [CW-1:0]         hit_copies_ff, hit_copies_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fftp_pkg::rsp_type     rsp_ff,       rsp_in;

   logic [63:0]           key_wide;
   logic [CW-1:0]         pg_cnt;
   logic [15:0]           pg_free;
   logic [15:0]           sub_a;
   logic [17:0]           diff;
   logic                  fits;
   logic                  out_free;
   logic [PCW-1:0]        page_next;
   logic                  last_page;
   logic [KCW-1:0]        base_next;
   logic [CW-1:0]         key_off;
   logic [KCW-1:0]        key_sum;
   logic                  advance;

   function automatic fftp_pkg::rsp_type make_rsp(input logic [2:0]  kind,
                                                  input logic [31:0] page,
                                                  input logic [31:0] value,
                                                  input logic        last);
      fftp_pkg::rsp_type r;
      r.result_kind = kind;
      r.page_index  = page[3:0];
      r.value       = value[6:0];
      r.last        = last;
      return r;
   endfunction

   assign pg_cnt    = page_rdata[CW-1:0];
   assign pg_free   = page_rdata[CW+15:CW];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign page_next = page_ff + PCW'(1);
   assign last_page = (page_next == pages_ff);
   assign base_next = base_ff + KCW'(MAX_RECORDS_PER_PAGE);
   assign key_wide  = {32'd0, req_data.key};

   // shared subtractor: free space against record cost
   assign sub_a = (state_ff == S_INS_NEW) ? usable_space : pg_free;
   assign diff  = {2'b00, sub_a} - {1'b0, cost_ff};
   assign fits  = !diff[17];

   always_comb begin
      case (state_ff)
         S_SR_SCAN: key_off = slot_ff;
         S_INS_CHK: key_off = pg_cnt;
         default:   key_off = '0;
      endcase
   end
   assign key_sum   = base_ff + KCW'(key_off);
   assign key_addr  = key_sum[KAW-1:0];
   assign key_wdata = key_ff;
   assign page_addr = page_ff[PAW-1:0];

   always_comb begin
      state_in      = state_ff;
      cost_in       = cost_ff;
      key_in        = key_ff;
      pages_in      = pages_ff;
      page_in       = page_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      copies_in     = copies_ff;
      cmp_pend_in   = cmp_pend_ff;
      hit_valid_in  = hit_valid_ff;
      hit_page_in   = hit_page_ff;
      hit_copies_in = hit_copies_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      page_we       = 1'b0;
      page_wdata    = {diff[15:0], pg_cnt + CW'(1)};
      key_we        = 1'b0;
      advance       = 1'b0;

      if (cmp_pend_ff && (key_rdata == key_ff)) begin
         copies_in = copies_ff + CW'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cost_in = 17'(req_data.record_size) + 17'(fftp_pkg::SlotOverhead);
               key_in  = key_wide[KEY_BITS-1:0];
               page_in = '0;
               base_in = '0;
               case (req_data.operation)
                  fftp_pkg::OP_INSERT: begin
                     state_in = (pages_ff == '0) ? S_INS_NEW : S_INS_RD;
                  end
                  fftp_pkg::OP_STATUS: begin
                     state_in = S_ST_TOT;
                  end
                  fftp_pkg::OP_SEARCH: begin
                     hit_valid_in = 1'b0;
                     state_in     = (pages_ff == '0) ? S_SR_FIN : S_SR_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if ((pg_cnt < CW'(MAX_RECORDS_PER_PAGE)) && fits) begin
               if (out_free) begin
                  page_we      = 1'b1;
                  key_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(fftp_pkg::KIND_INSERTED, 32'(page_ff),
                                          32'(pg_cnt + CW'(1)), 1'b1);
                  state_in     = S_IDLE;
               end
            end else begin
               page_in  = page_next;
               base_in  = base_next;
               state_in = last_page ? S_INS_NEW : S_INS_RD;
            end
         end
         S_INS_NEW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (fits && (pages_ff < PCW'(MAX_PAGES))) begin
                  page_we    = 1'b1;
                  page_wdata = {diff[15:0], CW'(1)};
                  key_we     = 1'b1;
                  pages_in   = pages_ff + PCW'(1);
                  rsp_in     = make_rsp(fftp_pkg::KIND_INSERTED, 32'(page_ff), 32'd1, 1'b1);
               end else begin
                  rsp_in = make_rsp(fftp_pkg::KIND_REJECTED, 32'd0, 32'd0, 1'b1);
               end
            end
         end
         S_ST_TOT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(fftp_pkg::KIND_TOTAL, 32'd0, 32'(pages_ff),
                                       pages_ff == '0);
               state_in     = (pages_ff == '0) ? S_IDLE : S_ST_RD;
            end
         end
         S_ST_RD: begin
            state_in = S_ST_EMIT;
         end
         S_ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(fftp_pkg::KIND_COUNT, 32'(page_ff), 32'(pg_cnt),
                                       last_page);
               page_in      = page_next;
               state_in     = last_page ? S_IDLE : S_ST_RD;
            end
         end
         S_SR_RD: begin
            state_in = S_SR_CHK;
         end
         S_SR_CHK: begin
            cnt_in      = pg_cnt;
            slot_in     = '0;
            copies_in   = '0;
            cmp_pend_in = 1'b0;
            state_in    = S_SR_SCAN;
         end
         S_SR_SCAN: begin
            if (slot_ff < cnt_ff) begin
               slot_in     = slot_ff + CW'(1);
               cmp_pend_in = 1'b1;
            end else begin
               cmp_pend_in = 1'b0;
               state_in    = S_SR_END;
            end
         end
         S_SR_END: begin
            if ((copies_ff != '0) && hit_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = make_rsp(fftp_pkg::KIND_HIT, 32'(hit_page_ff),
                                           32'(hit_copies_ff), 1'b0);
                  hit_page_in   = page_ff;
                  hit_copies_in = copies_ff;
                  advance       = 1'b1;
               end
            end else begin
               if (copies_ff != '0) begin
                  hit_valid_in  = 1'b1;
                  hit_page_in   = page_ff;
                  hit_copies_in = copies_ff;
               end
               advance = 1'b1;
            end
            if (advance) begin
               page_in  = page_next;
               base_in  = base_next;
               state_in = last_page ? S_SR_FIN : S_SR_RD;
            end
         end
         S_SR_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (hit_valid_ff) begin
                  rsp_in = make_rsp(fftp_pkg::KIND_HIT, 32'(hit_page_ff),
                                    32'(hit_copies_ff), 1'b1);
               end else begin
                  rsp_in = make_rsp(fftp_pkg::KIND_MISS, 32'd0, 32'd0, 1'b1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pages_ff     <= '0;
         cmp_pend_ff  <= 1'b0;
         hit_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pages_ff     <= pages_in;
         cmp_pend_ff  <= cmp_pend_in;
         hit_valid_ff <= hit_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cost_ff       <= cost_in;
      key_ff        <= key_in;
      page_ff       <= page_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      copies_ff     <= copies_in;
      hit_page_ff   <= hit_page_in;
      hit_copies_ff <= hit_copies_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      pages_ff <= PCW'(MAX_PAGES))
      else $error("page count beyond table size");

   a_key_with_page: assert property (@(posedge clock) disable iff (reset)
      key_we |-> page_we)
      else $error("key store written without page table update");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_data.operation == fftp_pkg::OP_INSERT ||
        req_data.operation == fftp_pkg::OP_STATUS ||
        req_data.operation == fftp_pkg::OP_SEARCH)) |=> req_stall)
      else $error("new transaction taken while previous one in progress");

   a_write_with_slot: assert property (@(posedge clock) disable iff (reset)
      page_we |-> (!rsp_valid_ff || !rsp_stall))
      else $error("insert committed while result register blocked");

   a_copies_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SR_SCAN) |-> (copies_ff <= slot_ff))
      else $error("copy count exceeds slots compared");
`endif

endmodule

>>> hw/rtl/first_fit_record_page_table_top.sv
// Top level of the first-fit record page table: usable-space register,
// page table RAM, key store RAM and the sequencer.
// Depends on fftp_pkg, fftp_ram and fftp_ctrl.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | fftp_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_stall | fftp_pkg::rsp_type
//   csr_    | in        | csr_valid/csr_ready | usable_space, 16 bits
//
// One transaction at a time; req_stall is high until its last result is in the result register.
// Insert reads and checks each page in turn and takes the first that fits, else opens a page
// or rejects; status gives the page total, then one count per page.
// Search reads each page's count and scans its key slots one at a time, bounded by the key
// store's single read port.
// Synchronous reset; no memory clearing pass.
// A stalled result holds the sequencer; the next result waits behind it.
module first_fit_record_page_table_top #(
   parameter int unsigned MAX_PAGES            = fftp_pkg::MaxPagesDefault,
   parameter int unsigned MAX_RECORDS_PER_PAGE = fftp_pkg::MaxRecordsDefault,
   parameter int unsigned KEY_BITS             = fftp_pkg::KeyBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fftp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fftp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   localparam int unsigned PAW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int unsigned CW   = $clog2(MAX_RECORDS_PER_PAGE + 1);
   localparam int unsigned KDEP = MAX_PAGES * MAX_RECORDS_PER_PAGE;
   localparam int unsigned KAW  = (KDEP > 1) ? $clog2(KDEP) : 1;

   logic [15:0]         usable_ff, usable_in;
   logic                page_we;
   logic [PAW-1:0]      page_addr;
   logic [CW+15:0]      page_wdata;
   logic [CW+15:0]      page_rdata;
   logic                key_we;
   logic [KAW-1:0]      key_addr;
   logic [KEY_BITS-1:0] key_wdata;
   logic [KEY_BITS-1:0] key_rdata;

   assign csr_ready = 1'b1;
   assign usable_in = (csr_valid && csr_ready) ? csr_data : usable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= fftp_pkg::UsableSpaceReset;
      end else begin
         usable_ff <= usable_in;
      end
   end

   fftp_ram #(
      .WIDTH (CW + 16),
      .DEPTH (MAX_PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .addr    (page_addr),
      .wr_data (page_wdata),
      .rd_data (page_rdata)
   );

   fftp_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (KDEP)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .addr    (key_addr),
      .wr_data (key_wdata),
      .rd_data (key_rdata)
   );

   fftp_ctrl #(
      .MAX_PAGES            (MAX_PAGES),
      .MAX_RECORDS_PER_PAGE (MAX_RECORDS_PER_PAGE),
      .KEY_BITS             (KEY_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .usable_space (usable_ff),
      .page_we      (page_we),
      .page_addr    (page_addr),
      .page_wdata   (page_wdata),
      .page_rdata   (page_rdata),
      .key_we       (key_we),
      .key_addr     (key_addr),
      .key_wdata    (key_wdata),
      .key_rdata    (key_rdata)
   );

endmodule

>>> dv/tb_first_fit_record_page_table_top.sv
`timescale 1ns / 100ps
// Testbench for first_fit_record_page_table_top: directed and random insert, status and search
// transactions, checked result by result against a scoreboard that models the page table.
// Depends on fftp_pkg and the RTL of the block.
module tb_first_fit_record_page_table_top;

   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int unsigned NUM_PAGES     = fftp_pkg::MaxPagesDefault;
   localparam int unsigned NUM_SLOTS     = fftp_pkg::MaxRecordsDefault;
   localparam int unsigned IDLE_LIMIT    = 20000;
   localparam int unsigned SETTLE_CYCLES = 64;

   class page_table_scoreboard;
      logic [15:0]       usable_space;
      int unsigned       page_count;
      logic [15:0]       free_bytes [NUM_PAGES];
      int unsigned       record_count [NUM_PAGES];
      logic [31:0]       page_keys [NUM_PAGES][NUM_SLOTS];
      fftp_pkg::rsp_type expected_results [$];
      int unsigned       errors;

      function new();
         usable_space = fftp_pkg::UsableSpaceReset;
         page_count   = 0;
         errors       = 0;
         foreach (record_count[p]) begin
            record_count[p] = 0;
            free_bytes[p]   = '0;
         end
      endfunction

      function void record_expected(logic [2:0] kind, int unsigned page, int unsigned count,
                                    bit last);
         fftp_pkg::rsp_type r;
         r.result_kind = kind;
         r.page_index  = 4'(page);
         r.value       = 7'(count);
         r.last        = last;
         expected_results.insert(expected_results.size(), r);
      endfunction

      function bit has_full_page();
         for (int p = 0; p < page_count; p++)
            if (record_count[p] == NUM_SLOTS) return 1'b1;
         return 1'b0;
      endfunction

      function void note_request(fftp_pkg::req_type req);
         logic [16:0] cost;
         int unsigned copies [NUM_PAGES];
         int          target;
         int          last_hit;
         cost = {1'b0, req.record_size} + 17'(fftp_pkg::SlotOverhead);
         case (req.operation)
            fftp_pkg::OP_INSERT: begin
               target = -1;
               for (int p = 0; p < page_count; p++)
                  if (target < 0 && record_count[p] < NUM_SLOTS &&
                      {1'b0, free_bytes[p]} >= cost)
                     target = p;
               if (target < 0 && cost <= {1'b0, usable_space} && page_count < NUM_PAGES) begin
                  target = page_count;
                  page_count++;
                  free_bytes[target]   = usable_space;
                  record_count[target] = 0;
               end
               if (target < 0) begin
                  record_expected(fftp_pkg::KIND_REJECTED, 0, 0, 1'b1);
               end else begin
                  page_keys[target][record_count[target]] = req.key;
                  record_count[target]++;
                  free_bytes[target] = free_bytes[target] - cost[15:0];
                  record_expected(fftp_pkg::KIND_INSERTED, target, record_count[target],
                                  1'b1);
               end
            end
            fftp_pkg::OP_STATUS: begin
               record_expected(fftp_pkg::KIND_TOTAL, 0, page_count, page_count == 0);
               for (int p = 0; p < page_count; p++)
                  record_expected(fftp_pkg::KIND_COUNT, p, record_count[p],
                                  p + 1 == page_count);
            end
            fftp_pkg::OP_SEARCH: begin
               last_hit = -1;
               for (int p = 0; p < page_count; p++) begin
                  copies[p] = 0;
                  for (int s = 0; s < record_count[p]; s++)
                     if (page_keys[p][s] == req.key) copies[p]++;
                  if (copies[p] != 0) last_hit = p;
               end
               if (last_hit < 0) begin
                  record_expected(fftp_pkg::KIND_MISS, 0, 0, 1'b1);
               end else begin
                  for (int p = 0; p < page_count; p++)
                     if (copies[p] != 0)
                        record_expected(fftp_pkg::KIND_HIT, p, copies[p], p == last_hit);
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(fftp_pkg::rsp_type got);
         fftp_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d page %0d value %0d last %0d",
                                      got.result_kind, got.page_index, got.value, got.last));
            return;
         end
         want = expected_results.pop_front();
         if (got.result_kind !== want.result_kind || got.page_index !== want.page_index ||
             got.value !== want.value || got.last !== want.last)
            report_mismatch($sformatf({"kind/page/value/last expected %0d/%0d/%0d/%0d",
                                       " got %0d/%0d/%0d/%0d"},
                                      want.result_kind, want.page_index, want.value, want.last,
                                      got.result_kind, got.page_index, got.value, got.last));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   fftp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   fftp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;

   page_table_scoreboard sb;
   bit          quiet = 1'b0;
   int unsigned idle_cycles = 0;
   logic [31:0] key_pool [8];

   first_fit_record_page_table_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic fftp_pkg::req_type make_req(logic [1:0] op, logic [15:0] size,
                                                  logic [31:0] key);
      fftp_pkg::req_type r;
      r.operation   = op;
      r.record_size = size;
      r.key         = key;
      return r;
   endfunction

   function automatic fftp_pkg::req_type random_req();
      logic [1:0]  op;
      logic [15:0] size;
      logic [31:0] key;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) op = fftp_pkg::OP_INSERT;
      else if (pick < 72) op = fftp_pkg::OP_STATUS;
      else if (pick < 95) op = fftp_pkg::OP_SEARCH;
      else op = OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 65) size = 16'($urandom_range(0, 40));
      else if (pick < 85) size = 16'($urandom_range(0, sb.usable_space));
      else if (pick < 95) size = (sb.usable_space >= 16'd4) ? sb.usable_space - 16'd4 : 16'd0;
      else size = 16'($urandom);
      key = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 7)] : $urandom;
      return make_req(op, size, key);
   endfunction

   // entered and left just after a falling edge
   task automatic send_req(fftp_pkg::req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic settle();
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_usable(logic [15:0] value);
      req_valid <= 1'b0;
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.usable_space = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int unsigned count);
      repeat (count) send_req(random_req());
   endtask

   initial begin
      int unsigned span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         span = pick_gap();
         if (span != 0) begin
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6) - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb_first_fit_record_page_table_top: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // empty file, unused code, oversized records, exact fit
      send_req(make_req(fftp_pkg::OP_STATUS, 16'h0000, 32'h0000_0000));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'hFFFF, 32'h0000_0000));
      send_req(make_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0001));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd4077, 32'h0000_0002));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd4076, 32'h0000_0000));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd0, 32'hFFFF_FFFF));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd0, 32'hFFFF_FFFF));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd100, 32'h0000_0000));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'd0, 32'hFFFF_FFFF));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'd0, 32'h0000_0000));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'd0, 32'h1234_5678));
      send_req(make_req(fftp_pkg::OP_STATUS, 16'd0, 32'h0000_0000));

      // existing pages keep their space when the register shrinks
      write_usable(16'd0);
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd0, 32'hA5A5_A5A5));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd4000, 32'h5A5A_5A5A));

      write_usable(16'hFFFF);
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd65531, 32'h0F0F_0F0F));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'hFFFF, 32'hF0F0_F0F0));
      send_req(make_req(fftp_pkg::OP_STATUS, 16'd0, 32'h0000_0000));
      send_req(make_req(OP_UNUSED, 16'($urandom), $urandom));

      write_usable(fftp_pkg::UsableSpaceReset);
      run_random(25);
      write_usable(16'($urandom_range(100, 600)));
      run_random(25);
      write_usable(16'hFFFF);
      quiet = 1'b1;
      run_random(25);
      quiet = 1'b0;

      // fill one page's slot list, then keep inserting past it
      write_usable(16'd1024);
      for (int i = 0; i < 70 && !sb.has_full_page(); i++)
         send_req(make_req(fftp_pkg::OP_INSERT, 16'($urandom_range(0, 3)), $urandom));
      repeat (4) send_req(make_req(fftp_pkg::OP_INSERT, 16'd0, $urandom));
      send_req(make_req(fftp_pkg::OP_STATUS, 16'd0, 32'h0000_0000));

      // every new page is filled exactly, so the table runs out
      write_usable(16'hFFFF);
      for (int i = 0; i < 20 && sb.page_count < NUM_PAGES; i++)
         send_req(make_req(fftp_pkg::OP_INSERT, 16'd65531, $urandom));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd65531, key_pool[2]));
      send_req(make_req(fftp_pkg::OP_INSERT, 16'd0, key_pool[3]));
      send_req(make_req(fftp_pkg::OP_STATUS, 16'd0, 32'h0000_0000));

      write_usable(16'($urandom_range(1, 65534)));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'd0, key_pool[3]));
      send_req(make_req(fftp_pkg::OP_SEARCH, 16'd0, $urandom));
      send_req(make_req(fftp_pkg::OP_STATUS, 16'd0, 32'h0000_0000));

      req_valid <= 1'b0;
      settle();
      if (sb.errors == 0) begin
         $display("tb_first_fit_record_page_table_top: done, clean");
      end else begin
         $display("tb_first_fit_record_page_table_top: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/fftp_pkg.sv
hw/rtl/fftp_ram.sv
hw/rtl/fftp_ctrl.sv
hw/rtl/first_fit_record_page_table_top.sv
dv/tb_first_fit_record_page_table_top.sv
